// ===== rtl/c8id_pkg.sv =====
// ----------------------------------------------------------------------------
// c8id_pkg
// Shared codes and types for the CHIP-8 / SCHIP instruction decoder.
// ----------------------------------------------------------------------------
package c8id_pkg;

  localparam int WORD_W = 16;
  localparam int MN_W   = 6;
  localparam int FORM_W = 4;
  localparam int REG_W  = 4;
  localparam int CIDX_W = 2;

  // mnemonic codes
  localparam logic [MN_W-1:0] MN_CLS   = 6'd0;
  localparam logic [MN_W-1:0] MN_RET   = 6'd1;
  localparam logic [MN_W-1:0] MN_SCR   = 6'd2;
  localparam logic [MN_W-1:0] MN_SCL   = 6'd3;
  localparam logic [MN_W-1:0] MN_EXIT  = 6'd4;
  localparam logic [MN_W-1:0] MN_LOW   = 6'd5;
  localparam logic [MN_W-1:0] MN_HIGH  = 6'd6;
  localparam logic [MN_W-1:0] MN_SCD   = 6'd7;
  localparam logic [MN_W-1:0] MN_JP    = 6'd8;
  localparam logic [MN_W-1:0] MN_CALL  = 6'd9;
  localparam logic [MN_W-1:0] MN_SE    = 6'd10;
  localparam logic [MN_W-1:0] MN_SNE   = 6'd11;
  localparam logic [MN_W-1:0] MN_LD    = 6'd12;
  localparam logic [MN_W-1:0] MN_ADD   = 6'd13;
  localparam logic [MN_W-1:0] MN_OR    = 6'd14;
  localparam logic [MN_W-1:0] MN_AND   = 6'd15;
  localparam logic [MN_W-1:0] MN_XOR   = 6'd16;
  localparam logic [MN_W-1:0] MN_SUB   = 6'd17;
  localparam logic [MN_W-1:0] MN_SHR   = 6'd18;
  localparam logic [MN_W-1:0] MN_SUBN  = 6'd19;
  localparam logic [MN_W-1:0] MN_SHL   = 6'd20;
  localparam logic [MN_W-1:0] MN_RND   = 6'd21;
  localparam logic [MN_W-1:0] MN_DRWH  = 6'd22;
  localparam logic [MN_W-1:0] MN_DRW   = 6'd23;
  localparam logic [MN_W-1:0] MN_SKP   = 6'd24;
  localparam logic [MN_W-1:0] MN_SKNP  = 6'd25;
  localparam logic [MN_W-1:0] MN_RDDT  = 6'd26;
  localparam logic [MN_W-1:0] MN_LDK   = 6'd27;
  localparam logic [MN_W-1:0] MN_WRDT  = 6'd28;
  localparam logic [MN_W-1:0] MN_WRST  = 6'd29;
  localparam logic [MN_W-1:0] MN_ADDI  = 6'd30;
  localparam logic [MN_W-1:0] MN_LDF   = 6'd31;
  localparam logic [MN_W-1:0] MN_LDFH  = 6'd32;
  localparam logic [MN_W-1:0] MN_LDB   = 6'd33;
  localparam logic [MN_W-1:0] MN_WRI   = 6'd34;
  localparam logic [MN_W-1:0] MN_RDI   = 6'd35;
  localparam logic [MN_W-1:0] MN_WRRPL = 6'd36;
  localparam logic [MN_W-1:0] MN_RDRPL = 6'd37;
  localparam logic [MN_W-1:0] MN_RAW   = 6'd38;

  // operand form codes
  localparam logic [FORM_W-1:0] FM_NONE         = 4'd0;
  localparam logic [FORM_W-1:0] FM_NIBBLE       = 4'd1;
  localparam logic [FORM_W-1:0] FM_ADDR         = 4'd2;
  localparam logic [FORM_W-1:0] FM_VX_BYTE      = 4'd3;
  localparam logic [FORM_W-1:0] FM_VX_VY        = 4'd4;
  localparam logic [FORM_W-1:0] FM_VX           = 4'd5;
  localparam logic [FORM_W-1:0] FM_VX_VY_NIBBLE = 4'd6;
  localparam logic [FORM_W-1:0] FM_I_ADDR       = 4'd7;
  localparam logic [FORM_W-1:0] FM_V0_ADDR      = 4'd8;
  localparam logic [FORM_W-1:0] FM_RAW          = 4'd9;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_HIRES    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SHIFT_VY = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_JUMP_VX  = 2'd2;

  typedef struct packed {
    logic hires;
    logic shift_vy;
    logic jump_vx;
  } cfg_t;

  typedef struct packed {
    logic [MN_W-1:0]   mnemonic;
    logic [FORM_W-1:0] form;
    logic [REG_W-1:0]  reg_x;
    logic [REG_W-1:0]  reg_y;
    logic [WORD_W-1:0] immediate;
  } result_t;

endpackage

// ===== rtl/c8id_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// c8id_cfg_regs
// Quirk mode registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module c8id_cfg_regs import c8id_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic              cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_q;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign cfg       = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_HIRES:    cfg_q.hires    <= cfg_data;
        CFG_SHIFT_VY: cfg_q.shift_vy <= cfg_data;
        CFG_JUMP_VX:  cfg_q.jump_vx  <= cfg_data;
        default: ;
      endcase
    end
  end

  a_hires_wr: assert property (@(posedge clk)
    (!rst && wr && cfg_index == CFG_HIRES) |=> cfg_q.hires == $past(cfg_data))
    else $error("hires mode not updated");

  a_other_wr: assert property (@(posedge clk) disable iff (rst)
    (!rst && wr && cfg_index != CFG_HIRES) |=> $stable(cfg_q.hires))
    else $error("hires mode changed by another index");

  a_reset: assert property (@(posedge clk) rst |=> cfg_q == '0)
    else $error("modes not cleared by reset");

endmodule

// ===== rtl/c8id_decode.sv =====
// ----------------------------------------------------------------------------
// c8id_decode
// Combinational decode of one instruction word into mnemonic, form and fields.
// ----------------------------------------------------------------------------
module c8id_decode import c8id_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [3:0]        top;
  logic [3:0]        nib;
  logic [7:0]        lo_byte;
  logic [MN_W-1:0]   mn;
  logic [FORM_W-1:0] fm;

  assign top     = word[15:12];
  assign nib     = word[3:0];
  assign lo_byte = word[7:0];

  always_comb begin
    mn = MN_RAW;
    fm = FM_RAW;
    unique case (top)
      4'h0: begin
        priority if (word == 16'h00E0) begin
          mn = MN_CLS;  fm = FM_NONE;
        end else if (word == 16'h00EE) begin
          mn = MN_RET;  fm = FM_NONE;
        end else if (word == 16'h00FD) begin
          mn = MN_EXIT; fm = FM_NONE;
        end else if (cfg.hires && word == 16'h00FB) begin
          mn = MN_SCR;  fm = FM_NONE;
        end else if (cfg.hires && word == 16'h00FC) begin
          mn = MN_SCL;  fm = FM_NONE;
        end else if (cfg.hires && word == 16'h00FE) begin
          mn = MN_LOW;  fm = FM_NONE;
        end else if (cfg.hires && word == 16'h00FF) begin
          mn = MN_HIGH; fm = FM_NONE;
        end else if (cfg.hires && word[15:4] == 12'h00C) begin
          mn = MN_SCD;  fm = FM_NIBBLE;
        end else begin
          mn = MN_RAW;  fm = FM_RAW;
        end
      end
      4'h1: begin mn = MN_JP;   fm = FM_ADDR;    end
      4'h2: begin mn = MN_CALL; fm = FM_ADDR;    end
      4'h3: begin mn = MN_SE;   fm = FM_VX_BYTE; end
      4'h4: begin mn = MN_SNE;  fm = FM_VX_BYTE; end
      4'h5: begin mn = MN_SE;   fm = FM_VX_VY;   end
      4'h6: begin mn = MN_LD;   fm = FM_VX_BYTE; end
      4'h7: begin mn = MN_ADD;  fm = FM_VX_BYTE; end
      4'h8: begin
        unique case (nib)
          4'h0: begin mn = MN_LD;   fm = FM_VX_VY; end
          4'h1: begin mn = MN_OR;   fm = FM_VX_VY; end
          4'h2: begin mn = MN_AND;  fm = FM_VX_VY; end
          4'h3: begin mn = MN_XOR;  fm = FM_VX_VY; end
          4'h4: begin mn = MN_ADD;  fm = FM_VX_VY; end
          4'h5: begin mn = MN_SUB;  fm = FM_VX_VY; end
          4'h6: begin mn = MN_SHR;  fm = cfg.shift_vy ? FM_VX_VY : FM_VX; end
          4'h7: begin mn = MN_SUBN; fm = FM_VX_VY; end
          4'hE: begin mn = MN_SHL;  fm = cfg.shift_vy ? FM_VX_VY : FM_VX; end
          default: begin mn = MN_RAW; fm = FM_RAW; end
        endcase
      end
      4'h9: begin mn = MN_SNE; fm = FM_VX_VY;  end
      4'hA: begin mn = MN_LD;  fm = FM_I_ADDR; end
      4'hB: begin mn = MN_JP;  fm = cfg.jump_vx ? FM_VX_BYTE : FM_V0_ADDR; end
      4'hC: begin mn = MN_RND; fm = FM_VX_BYTE; end
      4'hD: begin
        if (nib == 4'h0 && cfg.hires) begin
          mn = MN_DRWH; fm = FM_VX_VY;
        end else begin
          mn = MN_DRW;  fm = FM_VX_VY_NIBBLE;
        end
      end
      4'hE: begin
        priority if (lo_byte == 8'h9E) begin
          mn = MN_SKP;  fm = FM_VX;
        end else if (lo_byte == 8'hA1) begin
          mn = MN_SKNP; fm = FM_VX;
        end else begin
          mn = MN_RAW;  fm = FM_RAW;
        end
      end
      4'hF: begin
        unique case (lo_byte)
          8'h07: begin mn = MN_RDDT;  fm = FM_VX; end
          8'h0A: begin mn = MN_LDK;   fm = FM_VX; end
          8'h15: begin mn = MN_WRDT;  fm = FM_VX; end
          8'h18: begin mn = MN_WRST;  fm = FM_VX; end
          8'h1E: begin mn = MN_ADDI;  fm = FM_VX; end
          8'h29: begin mn = MN_LDF;   fm = FM_VX; end
          8'h30: begin
            mn = cfg.hires ? MN_LDFH : MN_RAW;
            fm = cfg.hires ? FM_VX   : FM_RAW;
          end
          8'h33: begin mn = MN_LDB;   fm = FM_VX; end
          8'h55: begin mn = MN_WRI;   fm = FM_VX; end
          8'h65: begin mn = MN_RDI;   fm = FM_VX; end
          8'h75: begin mn = MN_WRRPL; fm = FM_VX; end
          8'h85: begin mn = MN_RDRPL; fm = FM_VX; end
          default: begin mn = MN_RAW; fm = FM_RAW; end
        endcase
      end
      default: begin mn = MN_RAW; fm = FM_RAW; end
    endcase
  end

  always_comb begin
    res.mnemonic = mn;
    res.form     = fm;
    res.reg_x    = word[11:8];
    res.reg_y    = word[7:4];
    unique case (fm)
      FM_NIBBLE, FM_VX_VY_NIBBLE:      res.immediate = {12'h000, word[3:0]};
      FM_VX_BYTE:                      res.immediate = {8'h00, word[7:0]};
      FM_ADDR, FM_I_ADDR, FM_V0_ADDR:  res.immediate = {4'h0, word[11:0]};
      FM_RAW:                          res.immediate = word;
      default:                         res.immediate = '0;
    endcase
  end

endmodule

// ===== rtl/chip8_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_decoder
// CHIP-8 / SCHIP instruction decoder: one word in, one decoded beat out.
// An accepted word goes into the input register; its decoded beat is loaded
// into the result register, where it is shown until the receiver takes it.
// One word per cycle unless the output stalls; one combinational decode stage.
// The input register takes a word whenever it is empty or moving on, so a
// waiting result does not block the next input beat; that beat waits there.
// Reset clears both valid flags and all quirk modes to 0; beats in flight drop.
// ----------------------------------------------------------------------------
module chip8_instruction_decoder import c8id_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] instr_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MN_W-1:0]   mnemonic,
  output logic [FORM_W-1:0] operand_form,
  output logic [REG_W-1:0]  reg_x,
  output logic [REG_W-1:0]  reg_y,
  output logic [WORD_W-1:0] immediate,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic              cfg_data
);

  cfg_t              cfg;
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  result_t           dec;
  result_t           res;
  logic              advance;

  c8id_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  c8id_decode u_dec (
    .word (s1_word),
    .cfg  (cfg),
    .res  (dec)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word <= instr_word;
    end
    if (advance && s1_valid) begin
      res <= dec;
    end
  end

  assign mnemonic     = res.mnemonic;
  assign operand_form = res.form;
  assign reg_x        = res.reg_x;
  assign reg_y        = res.reg_y;
  assign immediate    = res.immediate;

  a_raw_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mnemonic == MN_RAW) == (operand_form == FM_RAW)))
    else $error("raw mnemonic and raw form disagree");

  a_no_imm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (operand_form == FM_NONE || operand_form == FM_VX ||
                   operand_form == FM_VX_VY)) |-> immediate == '0)
    else $error("non-zero immediate on a form without one");

  a_raw_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && operand_form == FM_RAW) |->
      (immediate[11:8] == reg_x && immediate[7:4] == reg_y))
    else $error("register fields differ from raw word");

  a_pipe_move: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("decoded beat dropped between stages");

endmodule
